[src/two_level_page_table_manager_top_defines.svh]
// Assertion macros used by the checker file of the page table manager.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_TOP_DEFINES_SVH

// Check a property outside of reset.
`define PTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PTM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ptm_pkg.sv]
// Shared types and constants of the two-level page table manager.
package ptm_pkg;

	// Table geometry; both counts are powers of two
	localparam int DIR_SLOTS   = 16;
	localparam int TABLE_SLOTS = 64;
	localparam int DSLOT_W     = $clog2(DIR_SLOTS);
	localparam int TSLOT_W     = $clog2(TABLE_SLOTS);
	localparam int STORE_DEPTH = DIR_SLOTS * TABLE_SLOTS;
	localparam int STORE_AW    = DSLOT_W + TSLOT_W;
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

	localparam int FRAME_W  = 20;
	localparam int OFFSET_W = 12;
	localparam int VA_W     = 22;
	localparam int ENTRY_W  = 32;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [CFG_W-1:0] LOW_RESET  = CFG_W'(1);
	localparam logic [CFG_W-1:0] HIGH_RESET = CFG_W'(16);

	// Request kinds
	localparam logic [1:0] KIND_XLATE = 2'd0;
	localparam logic [1:0] KIND_MAP   = 2'd1;
	localparam logic [1:0] KIND_UNMAP = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_MAPPED  = 2'd2;
	localparam logic [1:0] ST_RESV    = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNMAP_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAP_HIGH = 1'b1;

	// Decoded request as held in the queue
	typedef struct packed {
		logic [1:0]          kind;
		logic [DSLOT_W-1:0]  dslot;
		logic [TSLOT_W-1:0]  tslot;
		logic [OFFSET_W-1:0] offset;
		logic [FRAME_W-1:0]  frame;
		logic [OFFSET_W-1:0] flags;
		logic [FRAME_W-1:0]  spare;
	} cmd_t;

	// Result beat, status in the lowest bits
	typedef struct packed {
		logic [2:0]         pad;
		logic [FRAME_W-1:0] table_frame_out;
		logic               table_freed;
		logic [FRAME_W-1:0] page_frame_out;
		logic               page_freed;
		logic               spare_used;
		logic [31:0]        phys_addr;
		logic [1:0]         status;
	} res_t;

	// Queue handoff between front and back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

[src/ptm_ram.sv]
// Generic single-port RAM with registered read.
module ptm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[src/ptm_front.sv]
// Front end: accepts request beats, splits the address and queues them.
module ptm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [79:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic               pop,
	output ptm_pkg::qhead_t    head
);

	ptm_pkg::cmd_t             entry_q [ptm_pkg::QDEPTH];
	logic [ptm_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ptm_pkg::QCNT_W-1:0] cnt_q;
	ptm_pkg::cmd_t             dec;
	logic [9:0]                page;
	logic                      push, do_pop;

	// Split the virtual address into slots and offset
	always_comb begin
		page       = s_tdata[21:12];
		dec.kind   = s_tuser;
		dec.tslot  = page[ptm_pkg::TSLOT_W-1:0];
		dec.dslot  = page[ptm_pkg::TSLOT_W +: ptm_pkg::DSLOT_W];
		dec.offset = s_tdata[11:0];
		dec.frame  = s_tdata[41:22];
		dec.flags  = s_tdata[53:42];
		dec.spare  = s_tdata[73:54];
	end

	assign s_tready   = (cnt_q != ptm_pkg::QCNT_W'(ptm_pkg::QDEPTH));
	assign push       = s_tvalid && s_tready;
	assign do_pop     = pop && head.valid;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	// Store queued requests
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ptm_pkg::QPTR_W'(ptm_pkg::QDEPTH - 1)) ? '0 :
					wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ptm_pkg::QPTR_W'(ptm_pkg::QDEPTH - 1)) ? '0 :
					rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/ptm_back.sv]
// Back end: walks the directory and table store and builds results.
module ptm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptm_pkg::qhead_t               head,
	output logic                          pop,
	input  logic                          cfg_wen,
	input  logic [ptm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ptm_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output ptm_pkg::res_t                 res
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CLR  = 4'b0010,
		S_RD   = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	state_t                              st_q;
	ptm_pkg::cmd_t                       cmd_q;
	logic                                spare_used_q;
	logic [ptm_pkg::TSLOT_W-1:0]         clr_idx_q;
	logic [ptm_pkg::DIR_SLOTS-1:0]       dir_valid_q;
	logic [ptm_pkg::FRAME_W-1:0]         dir_frame_q [ptm_pkg::DIR_SLOTS];
	logic [ptm_pkg::CNT_W-1:0]           cnt_q [ptm_pkg::DIR_SLOTS];
	logic [ptm_pkg::CFG_W-1:0]           low_q, high_q;
	logic                                out_valid_q;
	ptm_pkg::res_t                       out_q;

	logic [ptm_pkg::STORE_AW-1:0]        ram_addr;
	logic                                ram_we;
	logic [ptm_pkg::ENTRY_W-1:0]         ram_wdata, ram_rdata;
	ptm_pkg::res_t                       nxt;
	logic                                wr_entry;
	logic [ptm_pkg::ENTRY_W-1:0]         wr_val;
	logic                                cnt_inc, cnt_dec, dir_clear;
	logic [ptm_pkg::CNT_W-1:0]           cnt_cur, cnt_new;
	logic                                present, range_bad;
	logic [ptm_pkg::CFG_W-1:0]           dslot_x;

	ptm_ram #(
		.WIDTH (ptm_pkg::ENTRY_W),
		.DEPTH (ptm_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign pop      = (st_q == S_IDLE) && head.valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign res      = out_q;

	// Work out the result of the current request from the fetched entry
	always_comb begin
		nxt        = '0;
		wr_entry   = 1'b0;
		wr_val     = '0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		dir_clear  = 1'b0;
		present    = dir_valid_q[cmd_q.dslot];
		cnt_cur    = cnt_q[cmd_q.dslot];
		cnt_new    = cnt_cur - ptm_pkg::CNT_W'(ram_rdata[0]);
		dslot_x    = ptm_pkg::CFG_W'(cmd_q.dslot);
		range_bad  = (dslot_x < low_q) || (dslot_x >= high_q);
		nxt.spare_used = spare_used_q;
		case (cmd_q.kind)
			ptm_pkg::KIND_XLATE: begin
				if (!present || ram_rdata == '0) begin
					nxt.status    = ptm_pkg::ST_MISS;
					nxt.phys_addr = '1;
				end else begin
					nxt.phys_addr = {ram_rdata[31:12], cmd_q.offset};
				end
			end
			ptm_pkg::KIND_MAP: begin
				if (ram_rdata != '0) begin
					nxt.status = ptm_pkg::ST_MAPPED;
				end else begin
					wr_entry = 1'b1;
					wr_val   = {cmd_q.frame, cmd_q.flags | 12'h001};
					cnt_inc  = 1'b1;
				end
			end
			ptm_pkg::KIND_UNMAP: begin
				if (range_bad) begin
					nxt.status = ptm_pkg::ST_RESV;
				end else if (present) begin
					wr_entry = 1'b1;
					cnt_dec  = ram_rdata[0];
					if (ram_rdata[0]) begin
						nxt.page_freed     = 1'b1;
						nxt.page_frame_out = ram_rdata[31:12];
					end
					if (cnt_new == '0) begin
						dir_clear           = 1'b1;
						nxt.table_freed     = 1'b1;
						nxt.table_frame_out = dir_frame_q[cmd_q.dslot];
					end
				end
			end
			default: begin
				nxt.status = ptm_pkg::ST_RESV;
			end
		endcase
	end

	// Drive the table store: clear sweep, fetch, write back
	always_comb begin
		ram_addr  = {cmd_q.dslot, cmd_q.tslot};
		ram_we    = 1'b0;
		ram_wdata = wr_val;
		case (st_q)
			S_CLR: begin
				ram_addr  = {cmd_q.dslot, clr_idx_q};
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			S_EXEC: begin
				ram_we = wr_entry;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Hold the current request and register its result beat
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
		if (st_q == S_EXEC) begin
			out_q <= nxt;
		end
	end

	// Sequence requests, keep directory, presence counts, unmap bounds and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			spare_used_q <= 1'b0;
			clr_idx_q    <= '0;
			dir_valid_q  <= '0;
			low_q        <= ptm_pkg::LOW_RESET;
			high_q       <= ptm_pkg::HIGH_RESET;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < ptm_pkg::DIR_SLOTS; i++) begin
				dir_frame_q[i] <= '0;
				cnt_q[i]       <= '0;
			end
		end else begin
			if (cfg_wen && cfg_idx == ptm_pkg::REG_UNMAP_LOW) begin
				low_q <= cfg_wdata;
			end
			if (cfg_wen && cfg_idx == ptm_pkg::REG_UNMAP_HIGH) begin
				high_q <= cfg_wdata;
			end
			if (st_q == S_EXEC) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (pop) begin
						spare_used_q <= 1'b0;
						clr_idx_q    <= '0;
						if (head.cmd.kind == ptm_pkg::KIND_MAP &&
							!dir_valid_q[head.cmd.dslot]) begin
							dir_valid_q[head.cmd.dslot] <= 1'b1;
							dir_frame_q[head.cmd.dslot] <= head.cmd.spare;
							cnt_q[head.cmd.dslot]       <= '0;
							spare_used_q                <= 1'b1;
							st_q                        <= S_CLR;
						end else begin
							st_q <= S_RD;
						end
					end
				end
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == ptm_pkg::TSLOT_W'(ptm_pkg::TABLE_SLOTS - 1)) begin
						st_q <= S_RD;
					end
				end
				S_RD: begin
					st_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cnt_inc) begin
						cnt_q[cmd_q.dslot] <= cnt_cur + 1'b1;
					end else if (cnt_dec) begin
						cnt_q[cmd_q.dslot] <= cnt_new;
					end
					if (dir_clear) begin
						dir_valid_q[cmd_q.dslot] <= 1'b0;
					end
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[src/two_level_page_table_manager_top.sv]
// Top level of the two-level page table manager.
// Each request goes from the queue head to its result by pop, fetch from the table
// store and execute; a map that installs a new table first clears that table one
// entry a cycle through the single store port. Up to two requests wait in the queue
// while a result waits to be taken. Table occupancy is tracked by a count per
// directory slot, so unmap needs no scan.
module two_level_page_table_manager_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// virt_addr[21:0], phys_frame[41:22], page_flags[53:42], spare_frame[73:54]
	input  logic [79:0]                   s_tdata,
	// kind[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], phys_addr[33:2], spare_used[34], page_freed[35],
	// page_frame_out[55:36], table_freed[56], table_frame_out[76:57]
	output logic [79:0]                   m_tdata,
	input  logic                          cfg_wen,
	input  logic [ptm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ptm_pkg::CFG_W-1:0]     cfg_wdata
);

	ptm_pkg::qhead_t head;
	logic            pop;
	ptm_pkg::res_t   res;

	ptm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.head     (head)
	);

	ptm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tdata = res;

endmodule

[src/ptm_checker.sv]
// Port-level checks of the page table manager and their binding.
`include "two_level_page_table_manager_top_defines.svh"

module ptm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	`PTM_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "result beat during reset")
	`PTM_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat changed")
	`PTM_ASSERT(a_miss_ones, m_tvalid && m_tdata[1:0] == ptm_pkg::ST_MISS |-> m_tdata[33:2] == '1, "miss without all-ones address")
	`PTM_ASSERT(a_resv_quiet, m_tvalid && m_tdata[1:0] == ptm_pkg::ST_RESV |-> m_tdata[76:34] == '0, "reserved status with side effects")

endmodule

bind two_level_page_table_manager_top ptm_checker u_ptm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
